// ----- sv/aabb_pkg.sv -----
// Package: commands, status codes and table sizes for the collision query table.
package aabb_pkg;
	localparam int unsigned MaxEntities  = 64;
	localparam int unsigned MaxColliders = 64;
	localparam int unsigned IdBits       = 16;
	localparam int unsigned CoordW       = 32;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RSVD      = 2'd3
	} status_t;
endpackage

// ----- sv/aabb_collision_query_table_core.sv -----
// Top level: entity and collider tables with box overlap queries.
//
// Channel   Dir  tdata fields (low bit first)                     tuser
// s_axis    in   entity_id[15:0] lo_x lo_y lo_z hi_x hi_y hi_z    command[1:0]
// m_axis    out  hit[0] status[2:1] (zero filled to 8 bits)        -
//
// Entity ids and valid bits sit in flip-flops, so an id lookup is one
// parallel compare. Positions and collider data live in synchronous RAMs
// with registered reads. Write and add: accept, execute, then done. Delete
// and query walk all collider slots, each slot in a read state then a
// compare state; a delete of an absent id goes from execute straight to
// done. One item is in work at a time; the result register frees the input
// side as soon as it is loaded. No clearing pass after reset: only the
// valid bits and control registers are reset. A stall on m_axis holds the
// result; the next item is still taken and worked, then waits in S_DONE
// until the result register is free.
module aabb_collision_query_table_core
	import aabb_pkg::*;
#(
	parameter int unsigned MAX_ENTITIES  = MaxEntities,
	parameter int unsigned MAX_COLLIDERS = MaxColliders,
	parameter int unsigned ID_BITS       = IdBits
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [207:0] s_axis_tdata, // entity_id, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
	input  logic [1:0]   s_axis_tuser, // command
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [7:0]   m_axis_tdata  // hit, status, zero pad
);
	localparam int unsigned EW = (MAX_ENTITIES  > 1) ? $clog2(MAX_ENTITIES)  : 1;
	localparam int unsigned CW = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
	localparam int unsigned KW = (ID_BITS < 16) ? ID_BITS : 16;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_RD   = 5'b00100,
		S_CMP  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;
	logic [KW-1:0] id_q;
	logic signed [CoordW-1:0] lo_q [3];
	logic signed [CoordW-1:0] hi_q [3];
	logic [CW-1:0] slot_q;
	logic hit_q;
	status_t st_q;
	logic [7:0] res_q;
	logic res_v_q;

	// Entity ids and valid bits in flops; collider valid in flops
	logic [MAX_ENTITIES-1:0]  ent_v_q;
	logic [KW-1:0]            ent_key_q [MAX_ENTITIES];
	logic [MAX_COLLIDERS-1:0] col_v_q;

	// RAMs
	logic [3*CoordW-1:0] pos_mem [MAX_ENTITIES];
	logic [KW+6*CoordW-1:0] col_mem [MAX_COLLIDERS];
	logic [3*CoordW-1:0] pos_rd_q;
	logic [KW+6*CoordW-1:0] col_rd_q;

	// Lookup of the command id, and of the lowest free entity and collider slots
	logic          hit_e;
	logic [EW-1:0] idx_e;
	logic          free_e_ok;
	logic [EW-1:0] free_e;
	logic          free_c_ok;
	logic [CW-1:0] free_c;

	always_comb begin
		hit_e = 1'b0; idx_e = '0; free_e_ok = 1'b0; free_e = '0;
		free_c_ok = 1'b0; free_c = '0;
		for (int i = MAX_ENTITIES-1; i >= 0; i--) begin
			if (ent_v_q[i] && ent_key_q[i] == id_q) begin
				hit_e = 1'b1; idx_e = EW'(i);
			end
			if (!ent_v_q[i]) begin
				free_e_ok = 1'b1; free_e = EW'(i);
			end
		end
		for (int i = MAX_COLLIDERS-1; i >= 0; i--) begin
			if (!col_v_q[i]) begin
				free_c_ok = 1'b1; free_c = CW'(i);
			end
		end
	end

	// Owner lookup for the collider just read
	logic [KW-1:0] own_rd;
	logic          own_ok;
	logic [EW-1:0] own_idx;
	assign own_rd = col_rd_q[KW+6*CoordW-1 -: KW];
	always_comb begin
		own_ok = 1'b0; own_idx = '0;
		for (int i = MAX_ENTITIES-1; i >= 0; i--) begin
			if (ent_v_q[i] && ent_key_q[i] == own_rd) begin
				own_ok = 1'b1; own_idx = EW'(i);
			end
		end
	end

	// Position RAM read address follows the owner found in S_RD
	logic [EW-1:0] pos_ra;
	assign pos_ra = own_idx;

	// Collider RAM read address runs one slot ahead during S_CMP
	logic [CW-1:0] col_ra;
	assign col_ra = (state_q == S_CMP) ? slot_q + 1'b1 : slot_q;

	// Overlap test at 33 bits, signed throughout
	logic ovl;
	always_comb begin
		logic signed [CoordW:0] gmin, gmax, p, lo33, hi33;
		ovl = 1'b1;
		for (int k = 0; k < 3; k++) begin
			p    = $signed({pos_rd_q[k*CoordW+CoordW-1], pos_rd_q[k*CoordW +: CoordW]});
			gmin = p + $signed({col_rd_q[k*CoordW+CoordW-1], col_rd_q[k*CoordW +: CoordW]});
			gmax = p + $signed({col_rd_q[(k+3)*CoordW+CoordW-1],
			                    col_rd_q[(k+3)*CoordW +: CoordW]});
			lo33 = $signed({lo_q[k][CoordW-1], lo_q[k]});
			hi33 = $signed({hi_q[k][CoordW-1], hi_q[k]});
			if (!(lo33 <= gmax && hi33 >= gmin))
				ovl = 1'b0;
		end
	end

	// Held owner validity from the read stage
	logic own_ok_s1;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = res_v_q;
	assign m_axis_tdata  = res_q;

	logic last_slot;
	assign last_slot = (slot_q == CW'(MAX_COLLIDERS-1));

	// result register loads when free or being drained this cycle
	logic res_load;
	assign res_load = (state_q == S_DONE) && (!res_v_q || m_axis_tready);

	// RAM ports
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && cmd_q == CMD_WRITE && (hit_e || free_e_ok))
			pos_mem[hit_e ? idx_e : free_e] <= {lo_q[2], lo_q[1], lo_q[0]};
		if (state_q == S_EXEC && cmd_q == CMD_ADD && free_c_ok)
			col_mem[free_c] <= {id_q, hi_q[2], hi_q[1], hi_q[0], lo_q[2], lo_q[1], lo_q[0]};
		col_rd_q <= col_mem[col_ra];
		pos_rd_q <= pos_mem[pos_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ent_v_q <= '0;
			col_v_q <= '0;
			res_v_q <= 1'b0;
			slot_q  <= '0;
			hit_q   <= 1'b0;
			st_q    <= ST_OK;
			own_ok_s1 <= 1'b0;
		end else begin
			if (res_load) res_v_q <= 1'b1;
			else if (m_axis_tready) res_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q <= cmd_t'(s_axis_tuser);
						id_q  <= KW'(s_axis_tdata[15:0]);
						for (int k = 0; k < 3; k++) begin
							lo_q[k] <= s_axis_tdata[16 + k*CoordW +: CoordW];
							hi_q[k] <= s_axis_tdata[112 + k*CoordW +: CoordW];
						end
						hit_q  <= 1'b0;
						st_q   <= ST_OK;
						slot_q <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (cmd_q)
						CMD_WRITE: begin
							if (hit_e || free_e_ok) begin
								ent_v_q[hit_e ? idx_e : free_e]   <= 1'b1;
								ent_key_q[hit_e ? idx_e : free_e] <= id_q;
							end else st_q <= ST_FULL;
							state_q <= S_DONE;
						end
						CMD_ADD: begin
							if (free_c_ok) col_v_q[free_c] <= 1'b1;
							else st_q <= ST_FULL;
							state_q <= S_DONE;
						end
						CMD_DELETE: begin
							if (hit_e) begin
								ent_v_q[idx_e] <= 1'b0;
								state_q <= S_RD;
							end else begin
								st_q <= ST_NOT_FOUND;
								state_q <= S_DONE;
							end
						end
						default: state_q <= S_RD;
					endcase
				end
				S_RD: begin
					// collider read data valid now; entity position read issued
					own_ok_s1 <= own_ok && col_v_q[slot_q];
					if (cmd_q == CMD_DELETE && col_v_q[slot_q] && own_rd == id_q)
						col_v_q[slot_q] <= 1'b0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cmd_q == CMD_QUERY && own_ok_s1 && ovl) hit_q <= 1'b1;
					if (last_slot) state_q <= S_DONE;
					else begin
						slot_q  <= slot_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (res_load) begin
						res_q   <= {5'b0, st_q, hit_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Note: the collider RAM is read one slot ahead in S_CMP, so col_rd_q
	// holds the current slot in S_RD and S_CMP; pos_rd_q is valid in S_CMP.

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_hit_query: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[2:1] == ST_OK)
		else $error("hit with bad status");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:3] == 5'b0) else $error("pad set");
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the collision query table: directed and random command streams checked against a local table model.
module tb_top
	import aabb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumEnt = MaxEntities;
	localparam int NumCol = MaxColliders;
	localparam longint CycleLimit = 3000000;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] id;
		logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	} req_t;

	typedef struct packed {
		logic    hit;
		status_t status;
	} resp_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [207:0] s_axis_tdata;  // entity_id, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
	logic [1:0]   s_axis_tuser;  // command
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [7:0]   m_axis_tdata;  // hit, status, zero pad

	aabb_collision_query_table_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// shadow tables
	bit                 ent_used [NumEnt];
	logic [15:0]        ent_id   [NumEnt];
	logic signed [31:0] ent_pos  [NumEnt][3];
	bit                 col_used [NumCol];
	logic [15:0]        col_owner[NumCol];
	logic signed [31:0] col_box  [NumCol][6];

	req_t  pending_reqs[$];
	resp_t awaited_resps[$];
	int    errors;
	int    send_idle_pct, recv_stall_pct;
	bit    hold_sender;
	int    accepted_cnt;
	int    drv_seen;
	longint cycles;

	function automatic int lookup_entity(logic [15:0] id);
		for (int i = 0; i < NumEnt; i++)
			if (ent_used[i] && ent_id[i] == id) return i;
		return -1;
	endfunction

	// apply one command to the shadow tables, return the expected response
	function automatic resp_t apply_command(req_t r);
		resp_t o;
		int e;
		logic signed [31:0] lo[3], hi[3];
		logic signed [32:0] gmin, gmax;
		bit ov;
		o.hit = 1'b0;
		o.status = ST_OK;
		lo = '{r.lo_x, r.lo_y, r.lo_z};
		hi = '{r.hi_x, r.hi_y, r.hi_z};
		case (r.cmd)
			CMD_WRITE: begin
				e = lookup_entity(r.id);
				if (e < 0)
					for (int i = 0; i < NumEnt; i++)
						if (!ent_used[i]) begin e = i; break; end
				if (e < 0) o.status = ST_FULL;
				else begin
					ent_used[e] = 1;
					ent_id[e] = r.id;
					for (int k = 0; k < 3; k++) ent_pos[e][k] = lo[k];
				end
			end
			CMD_ADD: begin
				e = -1;
				for (int i = 0; i < NumCol; i++)
					if (!col_used[i]) begin e = i; break; end
				if (e < 0) o.status = ST_FULL;
				else begin
					col_used[e] = 1;
					col_owner[e] = r.id;
					for (int k = 0; k < 3; k++) begin
						col_box[e][k] = lo[k];
						col_box[e][3+k] = hi[k];
					end
				end
			end
			CMD_DELETE: begin
				e = lookup_entity(r.id);
				if (e < 0) o.status = ST_NOT_FOUND;
				else begin
					ent_used[e] = 0;
					for (int i = 0; i < NumCol; i++)
						if (col_used[i] && col_owner[i] == r.id) col_used[i] = 0;
				end
			end
			default: begin
				for (int i = 0; i < NumCol && !o.hit; i++) begin
					if (!col_used[i]) continue;
					e = lookup_entity(col_owner[i]);
					if (e < 0) continue;
					ov = 1;
					for (int k = 0; k < 3; k++) begin
						// 33-bit corner sums, never overflow
						gmin = 33'(ent_pos[e][k]) + 33'(col_box[i][k]);
						gmax = 33'(ent_pos[e][k]) + 33'(col_box[i][3+k]);
						if (!(33'(lo[k]) <= gmax && 33'(hi[k]) >= gmin)) ov = 0;
					end
					if (ov) o.hit = 1;
				end
			end
		endcase
		return o;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// driver: offers queued items at the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			// a new item may be offered once the previous transfer has happened
			if (!s_axis_tvalid || accepted_cnt != drv_seen) begin
				drv_seen = accepted_cnt;
				if (pending_reqs.size() != 0 &&
				    !hold_sender && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1;
					s_axis_tuser  <= pending_reqs[0].cmd;
					s_axis_tdata  <= {pending_reqs[0].hi_z, pending_reqs[0].hi_y,
					                  pending_reqs[0].hi_x, pending_reqs[0].lo_z,
					                  pending_reqs[0].lo_y, pending_reqs[0].lo_x,
					                  pending_reqs[0].id};
				end else
					s_axis_tvalid <= 0;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: model on accepted input, compare on accepted output
	always @(posedge clk) begin
		resp_t got, want;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (s_axis_tvalid && s_axis_tready) begin
				awaited_resps.push_back(apply_command(pending_reqs.pop_front()));
				accepted_cnt++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.hit    = m_axis_tdata[0];
				got.status = status_t'(m_axis_tdata[2:1]);
				if (awaited_resps.size() == 0) begin
					$error("unexpected result: hit %0d status %0d", got.hit, got.status);
					errors++;
				end else begin
					want = awaited_resps.pop_front();
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, actual %0d", want.hit, got.hit);
						errors++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						errors++;
					end
				end
			end
		end
	end

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return $urandom();
			default: return $signed(32'($urandom_range(8192))) - 32'sd4096;
		endcase
	endfunction

	function automatic logic [15:0] rand_id();
		// a small pool keeps hits and repeat ids frequent
		if ($urandom_range(9) == 0) return 16'($urandom());
		return 16'($urandom_range(79));
	endfunction

	function automatic req_t make_req(cmd_t c, logic [15:0] id);
		req_t r;
		r.cmd = c;
		r.id = id;
		r.lo_x = rand_coord(); r.lo_y = rand_coord(); r.lo_z = rand_coord();
		r.hi_x = rand_coord(); r.hi_y = rand_coord(); r.hi_z = rand_coord();
		if (c == CMD_QUERY && $urandom_range(3) != 0) begin
			// mostly well-formed boxes
			if (r.lo_x > r.hi_x) {r.lo_x, r.hi_x} = {r.hi_x, r.lo_x};
			if (r.lo_y > r.hi_y) {r.lo_y, r.hi_y} = {r.hi_y, r.lo_y};
			if (r.lo_z > r.hi_z) {r.lo_z, r.hi_z} = {r.hi_z, r.lo_z};
		end
		return r;
	endfunction

	task automatic settle();
		while (pending_reqs.size() != 0 || awaited_resps.size() != 0) begin
			@(posedge clk);
			if (cycles > CycleLimit) begin
				$display("tb_top: errors");
				$finish;
			end
		end
		repeat (200) @(posedge clk);
	endtask

	initial begin
		req_t r;
		int phase_items;
		arst_n = 0;
		errors = 0;
		cycles = 0;
		accepted_cnt = 0;
		drv_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_sender = 0;
		m_axis_tready = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: absent delete, empty query, extremes, inverted box
		pending_reqs.push_back(make_req(CMD_DELETE, 16'd5));
		pending_reqs.push_back(make_req(CMD_QUERY, 16'd0));
		r = '{CMD_WRITE, 16'hffff, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0};
		pending_reqs.push_back(r);
		r = '{CMD_ADD, 16'hffff, 32'sh7fff_ffff, 32'sh8000_0000, -10, 32'sh7fff_ffff,
		      32'sh8000_0000, 10};
		pending_reqs.push_back(r);
		r = '{CMD_QUERY, 16'h0, 32'sh7fff_ffff, 32'sh8000_0000, 0, 32'sh7fff_ffff,
		      32'sh8000_0000, 0};
		pending_reqs.push_back(r);
		r = '{CMD_QUERY, 16'h0, 5, 0, 0, -5, 0, 0};   // inverted corners
		pending_reqs.push_back(r);
		r = '{CMD_ADD, 16'd7, -1, -1, -1, 1, 1, 1};    // owner absent
		pending_reqs.push_back(r);
		pending_reqs.push_back(r);                     // adjacent twins
		r = '{CMD_QUERY, 16'h0, 0, 0, 0, 0, 0, 0};
		pending_reqs.push_back(r);
		r = '{CMD_WRITE, 16'd7, 1, 1, 1, 0, 0, 0};
		pending_reqs.push_back(r);
		r = '{CMD_QUERY, 16'h0, 2, 2, 2, 2, 2, 2};     // touches corner exactly
		pending_reqs.push_back(r);
		r = '{CMD_WRITE, 16'd7, 100, 1, 1, 0, 0, 0};   // update in place
		pending_reqs.push_back(r);
		pending_reqs.push_back(r);
		pending_reqs.push_back(make_req(CMD_DELETE, 16'd7));
		r = '{CMD_QUERY, 16'h0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
		      32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
		pending_reqs.push_back(r);
		settle();

		// fill both tables past capacity
		for (int i = 0; i < NumEnt + 2; i++)
			pending_reqs.push_back(make_req(CMD_WRITE, 16'(1000 + i)));
		for (int i = 0; i < NumCol + 2; i++)
			pending_reqs.push_back(make_req(CMD_ADD, 16'(1000 + i % 8)));
		pending_reqs.push_back(make_req(CMD_QUERY, 16'd0));
		for (int i = 0; i < NumEnt; i++)
			pending_reqs.push_back(make_req(CMD_DELETE, 16'(1000 + i)));
		settle();

		// random phases with varying idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			phase_items = 0;
			while (phase_items < 400) begin
				case ($urandom_range(9))
					0, 1, 2: r = make_req(CMD_WRITE, rand_id());
					3, 4, 5: r = make_req(CMD_ADD, rand_id());
					6:       r = make_req(CMD_DELETE, rand_id());
					default: r = make_req(CMD_QUERY, rand_id());
				endcase
				if (r.cmd == CMD_ADD && $urandom_range(1)) begin
					// small local boxes in x and y around the owner make hits likely
					r.lo_x = -($urandom_range(4096)); r.hi_x = $urandom_range(4096);
					r.lo_y = -($urandom_range(4096)); r.hi_y = $urandom_range(4096);
				end
				pending_reqs.push_back(r);
				phase_items++;
				if (phase_items == 200 && ph == 1) begin
					// sender holds off until every result is back
					hold_sender = 1;
					wait (awaited_resps.size() == 0 && !s_axis_tvalid);
					hold_sender = 0;
				end
				if (pending_reqs.size() > 20) @(posedge clk);
				while (pending_reqs.size() > 20) @(posedge clk);
			end
			settle();
		end

		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("tb_top: errors");
			$finish;
		end
	end
endmodule
